[design/tksd_pkg.sv]
// Shared types and constants of the table-keyed stream decryptor.
`default_nettype none

package tksd_pkg;

   localparam int unsigned DATA_W   = 32;
   localparam int unsigned TABLE_D  = 256;
   localparam int unsigned ADDR_W   = 8;

   localparam logic [DATA_W-1:0] SEED_MASK  = 32'h5555_5555;
   localparam logic [DATA_W-1:0] TABLE_MULT = 32'd39916801;

   // Item kinds carried on req_tuser
   typedef enum logic [1:0] {
      OP_SEED = 2'd0,
      OP_WORD = 2'd1,
      OP_BYTE = 2'd2,
      OP_PEEK = 2'd3
   } opcode_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_LOOK = 2'd1,
      ST_FILL = 2'd2
   } state_type;

   // Write request from the table builder to the key table
   typedef struct packed {
      logic              we;
      logic              last;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
   } fill_wr_type;

endpackage

`default_nettype wire

[design/tksd_ram.sv]
// Generic single-port synchronous RAM with registered read data.
`default_nettype none

module tksd_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one access a cycle: write, or read into the registered read data
   always_ff @(posedge clock) begin
      if (en && we) begin
         mem_ff[addr] <= wdata;
      end
      if (en && !we) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[design/tksd_fill.sv]
// Key table builder: one rotate-and-multiply step and one table write a cycle.
`default_nettype none

module tksd_fill
   import tksd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DATA_W-1:0] seed,
   output fill_wr_type            fill_wr
);

   logic              active_ff, active_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [DATA_W-1:0] k_ff, k_in;
   logic [DATA_W-1:0] rot;
   logic [DATA_W-1:0] prod;
   logic              last;

   // next chain value: rotate right by one, multiply modulo 2^32
   assign rot  = {k_ff[0], k_ff[DATA_W-1:1]};
   assign prod = rot * TABLE_MULT;
   assign last = (idx_ff == ADDR_W'(TABLE_D - 1));

   always_comb begin
      active_in = active_ff;
      idx_in    = idx_ff;
      k_in      = k_ff;
      if (start) begin
         active_in = 1'b1;
         idx_in    = '0;
         k_in      = seed;
      end else if (active_ff) begin
         k_in   = prod;
         idx_in = idx_ff + 1'b1;
         if (last) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         idx_ff    <= '0;
      end else begin
         active_ff <= active_in;
         idx_ff    <= idx_in;
      end
      k_ff <= k_in;
   end

   assign fill_wr.we   = active_ff;
   assign fill_wr.last = active_ff && last;
   assign fill_wr.addr = idx_ff;
   assign fill_wr.data = prod;

endmodule

`default_nettype wire

[design/table_keyed_stream_decryptor.sv]
// Top level: stream decryptor with a running key and a 256-entry key table.
//
//  channel | dir | word contents
//  --------+-----+------------------------------------------------------
//  req_    | in  | tuser = opcode[1:0]; tdata = cipher_data[31:0]
//  rsp_    | out | tdata = plain_data[31:0] (bytes: plain in [7:0], rest 0)
//
//  Table reads: peek none, byte one, word one per cipher byte (all
//  through the single RAM port; the next item enters as the last entry arrives).
//  Seed: one table entry written per cycle by the builder.
//  Reset clears the running key and the sequencer; table contents are
//  undefined until the first seed. A result waits in the output register
//  while the next word's lookups go on; input stalls when it is full and unread.
`default_nettype none

module table_keyed_stream_decryptor
   import tksd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [DATA_W-1:0] req_tdata,   // [31:0] cipher_data
   input  wire logic [1:0]        req_tuser,   // [1:0] opcode
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic      [DATA_W-1:0] rsp_tdata    // [31:0] plain_data
);

   state_type         state_ff, state_in;
   logic [DATA_W-1:0] key_ff, key_in;
   logic [DATA_W-1:0] cipher_ff, cipher_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic [1:0]        last_ff, last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;

   opcode_type        op;
   logic              look_done;
   logic              take_ok;
   logic              acc;
   logic [DATA_W-1:0] key_now;
   logic [DATA_W-1:0] plain;
   logic [1:0]        nxt;
   logic              ram_en, ram_we;
   logic [ADDR_W-1:0] ram_addr;
   logic [DATA_W-1:0] ram_wdata, ram_rdata;
   fill_wr_type       fill_wr;
   logic              fill_start;

   assign op        = opcode_type'(req_tuser);
   assign look_done = (state_ff == ST_LOOK) && (cnt_ff == last_ff);
   assign take_ok   = (state_ff == ST_IDLE) || look_done;
   assign req_tready = take_ok && (!rsp_valid_ff || rsp_tready);
   assign acc       = req_tvalid && req_tready;
   assign fill_start = acc && (op == OP_SEED);
   assign nxt       = cnt_ff + 1'b1;

   // key with the table word that arrives this cycle folded in
   assign key_now = (state_ff == ST_LOOK) ? (key_ff ^ ram_rdata) : key_ff;

   // table builder
   tksd_fill u_fill (
      .clock   (clock),
      .reset   (reset),
      .start   (fill_start),
      .seed    (req_tdata ^ SEED_MASK),
      .fill_wr (fill_wr)
   );

   // key table
   tksd_ram #(
      .WIDTH (DATA_W),
      .DEPTH (TABLE_D)
   ) u_table (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_FILL: begin
            if (fill_wr.last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE, ST_LOOK: begin
            if (state_ff == ST_LOOK && !look_done) begin
               state_in = ST_LOOK;
            end else if (acc) begin
               unique case (op)
                  OP_SEED:          state_in = ST_FILL;
                  OP_WORD, OP_BYTE: state_in = ST_LOOK;
                  OP_PEEK:          state_in = ST_IDLE;
                  default:          state_in = ST_IDLE;
               endcase
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and RAM port control
   always_comb begin
      key_in       = key_ff;
      cipher_in    = cipher_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ram_en       = 1'b0;
      ram_we       = 1'b0;
      ram_addr     = cipher_ff[8*nxt +: 8];
      ram_wdata    = fill_wr.data;
      plain        = req_tdata ^ key_now;

      if (state_ff == ST_FILL) begin
         ram_en   = fill_wr.we;
         ram_we   = fill_wr.we;
         ram_addr = fill_wr.addr;
      end

      // lookups in flight: fold in the arriving entry, issue the next byte
      if (state_ff == ST_LOOK) begin
         key_in = key_now;
         if (!look_done) begin
            ram_en = 1'b1;
            cnt_in = nxt;
         end
      end

      if (acc) begin
         cipher_in = req_tdata;
         cnt_in    = '0;
         unique case (op)
            OP_SEED: begin
               key_in = req_tdata ^ SEED_MASK;
            end
            OP_WORD: begin
               last_in      = 2'd3;
               rsp_valid_in = 1'b1;
               rsp_data_in  = plain;
               ram_en       = 1'b1;
               ram_addr     = req_tdata[7:0];
            end
            OP_BYTE: begin
               last_in      = 2'd0;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{(DATA_W-8){1'b0}}, plain[7:0]};
               ram_en       = 1'b1;
               ram_addr     = req_tdata[7:0];
            end
            OP_PEEK: begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = plain;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         key_ff       <= '0;
         cnt_ff       <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         key_ff       <= key_in;
         cnt_ff       <= cnt_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cipher_ff   <= cipher_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // a seed always starts a table build
   a_seed_fill: assert property (@(posedge clock) disable iff (reset)
      fill_start |=> state_ff == ST_FILL && fill_wr.we && fill_wr.addr == '0)
      else $error("seed did not start table build");

   // table writes only during a build
   a_write_fill: assert property (@(posedge clock) disable iff (reset)
      fill_wr.we |-> state_ff == ST_FILL)
      else $error("table write outside build");

   // a new result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (acc && op != OP_SEED) |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten");

   // lookup counter stays within the item's byte count
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOOK |-> cnt_ff <= last_ff)
      else $error("lookup counter overran");

endmodule

`default_nettype wire

[test/table_keyed_stream_decryptor_tb.sv]
// Self-checking testbench for the table-keyed stream decryptor.
`default_nettype none

module table_keyed_stream_decryptor_tb;
   import tksd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_WORDS = 1700;
   localparam int unsigned FILL_CYCLES  = 300;    // covers a whole table build
   localparam int unsigned SETTLE_LIMIT = 50000;
   localparam int unsigned REPORT_MAX   = 10;

   // Tracks the running key and pad table, and holds the plaintext words due out
   class plain_scoreboard;
      logic [DATA_W-1:0] stream_key;
      logic [DATA_W-1:0] pad_table [TABLE_D];
      logic [DATA_W-1:0] plain_due [$];
      int unsigned       failures;

      function new();
         stream_key = '0;
         failures   = 0;
      endfunction

      function void log_failure(string msg);
         if (failures < REPORT_MAX) begin
            $display("%0t: %s", $realtime, msg);
         end
         failures++;
      endfunction

      // Queue a plaintext word behind those already due
      function void due_append(logic [DATA_W-1:0] word);
         plain_due = {plain_due, word};
      endfunction

      // Work out what an accepted request word produces
      function void note_cipher(opcode_type op, logic [DATA_W-1:0] cipher);
         logic [DATA_W-1:0] k;
         case (op)
            OP_SEED: begin
               k          = cipher ^ SEED_MASK;
               stream_key = k;
               for (int i = 0; i < TABLE_D; i++) begin
                  k            = {k[0], k[DATA_W-1:1]};
                  k            = k * TABLE_MULT;
                  pad_table[i] = k;
               end
            end
            OP_WORD: begin
               due_append(cipher ^ stream_key);
               stream_key ^= pad_table[cipher[7:0]]   ^ pad_table[cipher[15:8]]
                           ^ pad_table[cipher[23:16]] ^ pad_table[cipher[31:24]];
            end
            OP_BYTE: begin
               due_append({24'h0, cipher[7:0] ^ stream_key[7:0]});
               stream_key ^= pad_table[cipher[7:0]];
            end
            default: begin
               due_append(cipher ^ stream_key);
            end
         endcase
      endfunction

      // Compare a response word with the oldest plaintext due
      function void check_plain(logic [DATA_W-1:0] actual);
         logic [DATA_W-1:0] due;
         if (plain_due.size() == 0) begin
            log_failure($sformatf("unexpected response word %h", actual));
         end else begin
            due = plain_due.pop_front();
            if (actual !== due) begin
               log_failure($sformatf("plain_data mismatch: expected %h, got %h", due, actual));
            end
         end
      endfunction

      function int unsigned pending();
         return plain_due.size();
      endfunction
   endclass

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata  = '0;     // [31:0] cipher_data
   logic [1:0]        req_tuser  = OP_PEEK; // [1:0] opcode
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;           // [31:0] plain_data

   plain_scoreboard sb;
   int unsigned     burst_left = 0;
   int unsigned     run_left   = 0;
   int unsigned     stall_left = 0;

   table_keyed_stream_decryptor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit, well above the slowest legal run
   initial begin
      #5ms;
      $display("Simulation FAILED");
      $finish;
   end

   // Watch both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.note_cipher(opcode_type'(req_tuser), req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_plain(rsp_tdata);
         end
      end
   end

   // Receiver: runs of ready, some long, broken by short or long stalls
   always @(posedge clock) begin
      if (run_left > 0) begin
         rsp_tready <= 1'b1;
         run_left--;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         run_left   = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(0, 30);
         stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 24)
                                                  : $urandom_range(0, 3);
      end
   end

   // Offer one request word, in bursts with random gaps between them
   task automatic send_cipher(opcode_type op, logic [DATA_W-1:0] cipher);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 25);
         gap        = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30)
                                                  : $urandom_range(0, 2);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= cipher;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Hold off until every response has come, then let a table build finish
   task automatic settle();
      int unsigned waited;
      waited     = 0;
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0 && waited < SETTLE_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (FILL_CYCLES) @(posedge clock);
   endtask

   initial begin
      opcode_type        op;
      logic [DATA_W-1:0] cipher;
      int unsigned       pick;

      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Peeks need no table, so they may come before the first seed
      send_cipher(OP_PEEK, 32'h0000_0000);
      send_cipher(OP_PEEK, 32'hFFFF_FFFF);
      // Seed giving a zero key and an all-zero table
      send_cipher(OP_SEED, 32'h5555_5555);
      send_cipher(OP_WORD, 32'hFFFF_FFFF);
      send_cipher(OP_BYTE, 32'hFFFF_FFFF);
      // Seed giving an all-ones key
      send_cipher(OP_SEED, 32'hAAAA_AAAA);
      send_cipher(OP_WORD, 32'h0000_0000);
      send_cipher(OP_PEEK, 32'h0000_0000);
      send_cipher(OP_BYTE, 32'hFFFF_FF00);
      send_cipher(OP_BYTE, 32'h0000_00FF);
      send_cipher(OP_WORD, 32'hFFFF_FFFF);
      send_cipher(OP_WORD, 32'h00FF_00FF);
      // Back-to-back seeds, extreme raw values
      send_cipher(OP_SEED, 32'h0000_0000);
      send_cipher(OP_SEED, 32'hFFFF_FFFF);
      send_cipher(OP_WORD, 32'h1234_5678);
      send_cipher(OP_BYTE, 32'h0000_0080);
      send_cipher(OP_PEEK, 32'h8000_0000);
      send_cipher(OP_WORD, 32'h0000_0001);
      send_cipher(OP_WORD, 32'h8080_8080);
      send_cipher(OP_PEEK, 32'hFFFF_FFFF);
      settle();

      // Random stream, reseeded now and then
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            op = OP_SEED;
         end else if (pick < 50) begin
            op = OP_WORD;
         end else if (pick < 78) begin
            op = OP_BYTE;
         end else begin
            op = OP_PEEK;
         end
         cipher = $urandom;
         if ($urandom_range(0, 15) == 0) begin
            cipher = ($urandom_range(0, 1) == 0) ? '0 : '1;
         end
         send_cipher(op, cipher);
         if (n == RANDOM_WORDS / 2) begin
            settle();
         end
      end

      settle();
      if (sb.pending() != 0) begin
         sb.log_failure($sformatf("%0d response words never arrived", sb.pending()));
      end
      if (sb.failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

[table_keyed_stream_decryptor.f]
design/tksd_pkg.sv
design/tksd_ram.sv
design/tksd_fill.sv
design/table_keyed_stream_decryptor.sv
test/table_keyed_stream_decryptor_tb.sv
